// ===== sv/tmcs_pkg.sv =====
package tmcs_pkg;

    localparam int MAX_MIPS     = 16;
    localparam int FORMAT_COUNT = 61;

    localparam int FMT_W     = 6;
    localparam int DIM_W     = 15;
    localparam int DEPTH_W   = 12;
    localparam int CNT_W     = 5;
    localparam int LVL_W     = 4;
    localparam int BYTES_W   = 5;
    localparam int ROW_W     = 19;
    localparam int SLICE_W   = 33;
    localparam int MIPB_W    = 44;
    localparam int TOTAL_W   = 45;

    // Intermediate product widths before saturation.
    localparam int BXB_W       = DIM_W + BYTES_W;
    localparam int SLICE_RAW_W = BXB_W + DIM_W;
    localparam int MIPB_RAW_W  = SLICE_RAW_W + DEPTH_W;

    // Compressed formats use 4x4 blocks.
    localparam int BLK_SHIFT = 2;

    localparam int Q_DEPTH = 2;
    localparam int Q_PTR_W = $clog2(Q_DEPTH);
    localparam int Q_CNT_W = $clog2(Q_DEPTH + 1);

    typedef struct packed {
        logic [FMT_W-1:0]   pixel_format;
        logic [DIM_W-1:0]   base_width;
        logic [DIM_W-1:0]   base_height;
        logic [DEPTH_W-1:0] base_depth;
        logic [CNT_W-1:0]   mip_count;
    } request_t;

    typedef struct packed {
        logic [LVL_W-1:0]   mip_level;
        logic [ROW_W-1:0]   row_pitch;
        logic [SLICE_W-1:0] slice_pitch;
        logic [MIPB_W-1:0]  mip_bytes;
        logic [TOTAL_W-1:0] running_total;
        logic               last;
    } result_t;

    typedef struct packed {
        logic [BYTES_W-1:0] bytes;
        logic               blk4;
    } fmt_t;

    // Classified request, as held between front and back.
    typedef struct packed {
        logic [BYTES_W-1:0] bytes;
        logic               blk4;
        logic [DIM_W-1:0]   base_width;
        logic [DIM_W-1:0]   base_height;
        logic [DEPTH_W-1:0] base_depth;
        logic [LVL_W-1:0]   last_level;
    } job_t;

    typedef struct packed {
        logic [LVL_W-1:0] lvl;
        logic             first;
        logic             last;
    } lvl_ctrl_t;

    // Queue handshake seen by the back end.
    typedef struct packed {
        logic head_valid;
        logic pop;
    } q_ctrl_t;

    function automatic fmt_t fmt_lookup(input logic [FMT_W-1:0] idx);
        fmt_t f;
        f = '0;
        unique case (idx) inside
            [6'd1:6'd4]:   f = '{bytes: 5'd1,  blk4: 1'b0};
            [6'd5:6'd16]:  f = '{bytes: 5'd2,  blk4: 1'b0};
            [6'd17:6'd31]: f = '{bytes: 5'd4,  blk4: 1'b0};
            [6'd32:6'd39]: f = '{bytes: 5'd8,  blk4: 1'b0};
            [6'd40:6'd42]: f = '{bytes: 5'd12, blk4: 1'b0};
            [6'd43:6'd45]: f = '{bytes: 5'd16, blk4: 1'b0};
            6'd46:         f = '{bytes: 5'd4,  blk4: 1'b0};
            6'd47:         f = '{bytes: 5'd8,  blk4: 1'b1};
            [6'd48:6'd49]: f = '{bytes: 5'd16, blk4: 1'b1};
            [6'd50:6'd51]: f = '{bytes: 5'd8,  blk4: 1'b1};
            [6'd52:6'd56]: f = '{bytes: 5'd16, blk4: 1'b1};
            6'd57:         f = '{bytes: 5'd2,  blk4: 1'b0};
            [6'd58:6'd59]: f = '{bytes: 5'd4,  blk4: 1'b0};
            6'd60:         f = '{bytes: 5'd8,  blk4: 1'b0};
            default:       f = '0;
        endcase
        return f;
    endfunction

endpackage

// ===== sv/tmcs_front.sv =====
module tmcs_front (
    input  logic              s_valid,
    output logic              s_ready,
    input  tmcs_pkg::request_t s_request,
    output logic              push_valid,
    input  logic              push_ready,
    output tmcs_pkg::job_t    push_job
);
    import tmcs_pkg::*;

    fmt_t fmt;

    assign s_ready    = push_ready;
    assign push_valid = s_valid;

    always_comb begin
        fmt = '0;
        if (s_request.pixel_format < FMT_W'(FORMAT_COUNT)) begin
            fmt = fmt_lookup(s_request.pixel_format);
        end
        push_job.bytes       = fmt.bytes;
        push_job.blk4        = fmt.blk4;
        push_job.base_width  = s_request.base_width;
        push_job.base_height = s_request.base_height;
        push_job.base_depth  = s_request.base_depth;
        push_job.last_level  = '0;
        // An empty mip chain still gives one all-zero result: drop the format.
        priority if (s_request.mip_count == '0) begin
            push_job.bytes = '0;
        end else if (s_request.mip_count > CNT_W'(MAX_MIPS)) begin
            push_job.last_level = LVL_W'(MAX_MIPS - 1);
        end else begin
            push_job.last_level = LVL_W'(s_request.mip_count - CNT_W'(1));
        end
    end

endmodule

// ===== sv/tmcs_queue.sv =====
module tmcs_queue (
    input  logic           aclk,
    input  logic           aresetn,
    input  logic           push_valid,
    output logic           push_ready,
    input  tmcs_pkg::job_t push_job,
    output tmcs_pkg::job_t head_job,
    output logic           head_valid,
    input  logic           pop
);
    import tmcs_pkg::*;

    job_t               entry_reg [Q_DEPTH];
    logic [Q_PTR_W-1:0] wr_ptr_reg, wr_ptr_next;
    logic [Q_PTR_W-1:0] rd_ptr_reg, rd_ptr_next;
    logic [Q_CNT_W-1:0] count_reg, count_next;
    logic               push;

    assign push_ready = (count_reg != Q_CNT_W'(Q_DEPTH));
    assign head_valid = (count_reg != '0);
    assign head_job   = entry_reg[rd_ptr_reg];
    assign push       = push_valid && push_ready;

    always_comb begin
        wr_ptr_next = push ? wr_ptr_reg + 1'b1 : wr_ptr_reg;
        rd_ptr_next = pop ? rd_ptr_reg + 1'b1 : rd_ptr_reg;
        count_next  = count_reg;
        unique case ({push, pop})
            2'b10:   count_next = count_reg + 1'b1;
            2'b01:   count_next = count_reg - 1'b1;
            default: count_next = count_reg;
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end else begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (push) begin
            entry_reg[wr_ptr_reg] <= push_job;
        end
    end

endmodule

// ===== sv/tmcs_back.sv =====
module tmcs_back (
    input  logic              aclk,
    input  logic              aresetn,
    input  tmcs_pkg::job_t    head_job,
    input  logic              head_valid,
    output logic              pop,
    output logic              m_valid,
    input  logic              m_ready,
    output tmcs_pkg::result_t m_result
);
    import tmcs_pkg::*;

    function automatic logic [DIM_W-1:0] to_blocks(input logic [DIM_W-1:0] s,
                                                   input logic blk4);
        logic [DIM_W:0] r;
        r = blk4 ? (({1'b0, s} + (DIM_W+1)'(3)) >> BLK_SHIFT) : {1'b0, s};
        return (r == '0) ? DIM_W'(1) : r[DIM_W-1:0];
    endfunction

    q_ctrl_t q;
    logic    adv, issue;

    logic [LVL_W-1:0] lvl_reg, lvl_next;

    logic                s1_vld_reg;
    lvl_ctrl_t           s1_ctrl_reg, s1_ctrl_next;
    logic [BYTES_W-1:0]  s1_bytes_reg;
    logic [DIM_W-1:0]    s1_bx_reg, s1_bx_next, s1_by_reg, s1_by_next;
    logic [DEPTH_W-1:0]  s1_dz_reg, s1_dz_next, dz_shift;

    logic                s2_vld_reg;
    lvl_ctrl_t           s2_ctrl_reg;
    logic [BXB_W-1:0]    s2_bxb_reg, s2_bxb_next;
    logic [DIM_W-1:0]    s2_by_reg;
    logic [DEPTH_W-1:0]  s2_dz_reg;

    logic                 s3_vld_reg;
    lvl_ctrl_t            s3_ctrl_reg;
    logic [ROW_W-1:0]     s3_row_reg;
    logic [SLICE_RAW_W-1:0] s3_slice_reg, s3_slice_next;
    logic [DEPTH_W-1:0]   s3_dz_reg;

    logic                 s4_vld_reg;
    lvl_ctrl_t            s4_ctrl_reg;
    logic [ROW_W-1:0]     s4_row_reg;
    logic [SLICE_W-1:0]   s4_slice_reg, s4_slice_next;
    logic [MIPB_RAW_W-1:0] s4_mipb_reg, s4_mipb_next;

    logic                 m_valid_reg;
    result_t              m_result_reg, m_result_next;
    logic [MIPB_W-1:0]    mipb_sat;
    logic [TOTAL_W:0]     total_sum;

    // Whole pipeline advances together whenever the output slot frees up.
    assign adv          = !m_valid_reg || m_ready;
    assign q.head_valid = head_valid;
    assign issue        = adv && q.head_valid;
    assign q.pop        = issue && (lvl_reg == head_job.last_level);
    assign pop          = q.pop;

    always_comb begin
        lvl_next = lvl_reg;
        priority if (q.pop) begin
            lvl_next = '0;
        end else if (issue) begin
            lvl_next = lvl_reg + 1'b1;
        end
        s1_ctrl_next.lvl   = lvl_reg;
        s1_ctrl_next.first = (lvl_reg == '0);
        s1_ctrl_next.last  = (lvl_reg == head_job.last_level);
        s1_bx_next = to_blocks(head_job.base_width >> lvl_reg, head_job.blk4);
        s1_by_next = to_blocks(head_job.base_height >> lvl_reg, head_job.blk4);
        dz_shift   = head_job.base_depth >> lvl_reg;
        s1_dz_next = (dz_shift == '0) ? DEPTH_W'(1) : dz_shift;

        s2_bxb_next   = BXB_W'(s1_bx_reg) * BXB_W'(s1_bytes_reg);
        s3_slice_next = SLICE_RAW_W'(s2_bxb_reg) * SLICE_RAW_W'(s2_by_reg);
        s4_mipb_next  = MIPB_RAW_W'(s3_slice_reg) * MIPB_RAW_W'(s3_dz_reg);
        s4_slice_next = (|s3_slice_reg[SLICE_RAW_W-1:SLICE_W]) ? '1
                                                              : s3_slice_reg[SLICE_W-1:0];

        mipb_sat  = (|s4_mipb_reg[MIPB_RAW_W-1:MIPB_W]) ? '1 : s4_mipb_reg[MIPB_W-1:0];
        total_sum = (s4_ctrl_reg.first ? (TOTAL_W+1)'(0)
                                       : {1'b0, m_result_reg.running_total})
                  + (TOTAL_W+1)'(mipb_sat);

        m_result_next.mip_level     = s4_ctrl_reg.lvl;
        m_result_next.row_pitch     = s4_row_reg;
        m_result_next.slice_pitch   = s4_slice_reg;
        m_result_next.mip_bytes     = mipb_sat;
        m_result_next.running_total = total_sum[TOTAL_W] ? '1 : total_sum[TOTAL_W-1:0];
        m_result_next.last          = s4_ctrl_reg.last;
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            lvl_reg     <= '0;
            s1_vld_reg  <= 1'b0;
            s2_vld_reg  <= 1'b0;
            s3_vld_reg  <= 1'b0;
            s4_vld_reg  <= 1'b0;
            m_valid_reg <= 1'b0;
        end else begin
            lvl_reg <= lvl_next;
            if (adv) begin
                s1_vld_reg  <= issue;
                s2_vld_reg  <= s1_vld_reg;
                s3_vld_reg  <= s2_vld_reg;
                s4_vld_reg  <= s3_vld_reg;
                m_valid_reg <= s4_vld_reg;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (adv) begin
            s1_ctrl_reg  <= s1_ctrl_next;
            s1_bytes_reg <= head_job.bytes;
            s1_bx_reg    <= s1_bx_next;
            s1_by_reg    <= s1_by_next;
            s1_dz_reg    <= s1_dz_next;

            s2_ctrl_reg <= s1_ctrl_reg;
            s2_bxb_reg  <= s2_bxb_next;
            s2_by_reg   <= s1_by_reg;
            s2_dz_reg   <= s1_dz_reg;

            s3_ctrl_reg  <= s2_ctrl_reg;
            s3_row_reg   <= s2_bxb_reg[ROW_W-1:0];
            s3_slice_reg <= s3_slice_next;
            s3_dz_reg    <= s2_dz_reg;

            s4_ctrl_reg  <= s3_ctrl_reg;
            s4_row_reg   <= s3_row_reg;
            s4_slice_reg <= s4_slice_next;
            s4_mipb_reg  <= s4_mipb_next;

            if (s4_vld_reg) begin
                m_result_reg <= m_result_next;
            end
        end
    end

    assign m_valid  = m_valid_reg;
    assign m_result = m_result_reg;

endmodule

// ===== sv/texture_mip_chain_size_core.sv =====
// The first result of a request passes the queue entry, stages s1 to s4 and the output register.
// One result per cycle while m_ready does not stall the output; a request occupies the level
//   sequencer for max(1, min(mip_count, 16)) levels, so up to 16 levels per request.
// The front takes a new request whenever the two-entry queue has room.
// Reset: synchronous, active low; clears queue pointers, level counter and valid bits.
module texture_mip_chain_size_core (
    input  logic               aclk,
    input  logic               aresetn,
    input  logic               s_valid,
    output logic               s_ready,
    input  tmcs_pkg::request_t s_request,
    output logic               m_valid,
    input  logic               m_ready,
    output tmcs_pkg::result_t  m_result
);
    import tmcs_pkg::*;

    // Front: format lookup, mip count clamping, empty-chain handling.
    logic push_valid, push_ready;
    job_t push_job;

    // Queue head as seen by the back end.
    job_t head_job;
    logic head_valid, pop;

    tmcs_front u_front (
        .s_valid    (s_valid),
        .s_ready    (s_ready),
        .s_request  (s_request),
        .push_valid (push_valid),
        .push_ready (push_ready),
        .push_job   (push_job)
    );

    // Short queue: lets the front keep taking requests while the back drains levels.
    tmcs_queue u_queue (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .push_valid (push_valid),
        .push_ready (push_ready),
        .push_job   (push_job),
        .head_job   (head_job),
        .head_valid (head_valid),
        .pop        (pop)
    );

    // Back: level sequencer feeding a stalling pipeline:
    // block counts, bytes per row, slice product, depth product, saturate and accumulate.
    tmcs_back u_back (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .head_job   (head_job),
        .head_valid (head_valid),
        .pop        (pop),
        .m_valid    (m_valid),
        .m_ready    (m_ready),
        .m_result   (m_result)
    );

    // Level 0 starts the running total from its own size.
    a_first_total: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_valid && m_result.mip_level == '0)
            |-> (m_result.running_total == TOTAL_W'(m_result.mip_bytes)))
        else $error("running total at level 0 differs from mip size");

    // A zero row means a zero-sized format, so the slice must be zero too.
    a_row_slice: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid |-> ((m_result.row_pitch == '0) == (m_result.slice_pitch == '0)))
        else $error("row pitch and slice pitch disagree on zero");

    // Depth is clamped to at least one, so a level is never smaller than one slice.
    a_mip_ge_slice: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid |-> (m_result.mip_bytes >= MIPB_W'(m_result.slice_pitch)))
        else $error("mip size below slice pitch");

    // No push is lost: a request seen while the queue is full must be held off.
    a_no_overrun: assert property (@(posedge aclk) disable iff (!aresetn)
        (s_valid && !push_ready) |-> !s_ready)
        else $error("request accepted into a full queue");

endmodule
